@@ rtl/mlprq_pkg.sv @@
// Shared types and codes for the multilevel priority ready queue.
// No dependencies; imported by every module of the block.
package mlprq_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADPRIO = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Operation codes on the func field
  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  // Controller states
  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic load_index;  // capture storage read data into the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read;   // current input is a dequeue that hits a level
  } dp_stat_t;

endpackage

@@ rtl/mlprq_datapath.sv @@
// Datapath: per-level pointers and counts, entry storage, result register.
// Depends on mlprq_pkg.
module mlprq_datapath
  import mlprq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_LEVELS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output dp_stat_t   stat,
  input  logic       func,
  input  logic [2:0] priority_req,
  input  logic [5:0] proc_index,
  output logic [1:0] status,
  output logic [5:0] out_index,
  output logic [1:0] out_priority,
  output logic       all_empty
);

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int AW  = LVW + PW;
  localparam int MEM_DEPTH = 1 << AW;

  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] tail [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];
  logic [CW-1:0] count_next [NUM_LEVELS];
  logic [5:0]    mem [MEM_DEPTH];
  logic [5:0]    rd_data;

  logic           prio_ok;
  logic [LVW-1:0] enq_lvl;
  logic           enq_full;
  logic           enq_ok;
  logic           found;
  logic [LVW-1:0] sel;
  logic           deq_ok;
  logic           empty_after;
  logic [1:0]     status_next;

  // Decode enqueue target
  always_comb begin
    prio_ok  = (int'(priority_req) < NUM_LEVELS);
    enq_lvl  = LVW'(priority_req);
    enq_full = prio_ok && (count[enq_lvl] == CW'(QUEUE_DEPTH));
    enq_ok   = (func == FN_ENQ) && prio_ok && !enq_full;
  end

  // Pick the most urgent non-empty level
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        sel   = LVW'(i);
      end
    end
    deq_ok = (func == FN_DEQ) && found;
    stat.need_read = deq_ok;
  end

  // Counts after this step and the empty flag that follows
  always_comb begin
    empty_after = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      count_next[i] = count[i];
      if (enq_ok && (enq_lvl == LVW'(i))) begin
        count_next[i] = count[i] + 1'b1;
      end
      if (deq_ok && (sel == LVW'(i))) begin
        count_next[i] = count[i] - 1'b1;
      end
      if (count_next[i] != '0) begin
        empty_after = 1'b0;
      end
    end
  end

  // Result status
  always_comb begin
    if (func == FN_ENQ) begin
      if (!prio_ok) begin
        status_next = ST_BADPRIO;
      end else if (enq_full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else begin
      status_next = found ? ST_OK : ST_EMPTY;
    end
  end

  // Advance pointers and counts on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (cmd.take) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count[i] <= count_next[i];
      end
      if (enq_ok) begin
        tail[enq_lvl] <= (tail[enq_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : tail[enq_lvl] + 1'b1;
      end
      if (deq_ok) begin
        head[sel] <= (head[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : head[sel] + 1'b1;
      end
    end
  end

  // Entry storage: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && enq_ok) begin
      mem[{enq_lvl, tail[enq_lvl]}] <= proc_index;
    end
    if (cmd.take && deq_ok) begin
      rd_data <= mem[{sel, head[sel]}];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      status       <= status_next;
      out_index    <= '0;
      out_priority <= deq_ok ? 2'(sel) : 2'd0;
      all_empty    <= empty_after;
    end else if (cmd.load_index) begin
      out_index    <= rd_data;
    end
  end

endmodule

@@ rtl/mlprq_ctrl.sv @@
// Controller: handshake sequencing and result valid flag.
// Depends on mlprq_pkg.
module mlprq_ctrl
  import mlprq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.load_index = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (stat.need_read) begin
            state_next = S_READ;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.load_index = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // No new transfer while a storage read is in flight
  a_no_take_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !in_ready)
    else $error("input taken during storage read");

  // The read cycle always presents a result next
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> out_valid)
    else $error("no result after storage read");

  // A transfer that needs no read shows its result without passing through the read state
  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && !stat.need_read) |=> (out_valid && state == S_IDLE))
    else $error("result missing after direct transfer");

  // Read data is captured only into a free result slot
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_index |-> !out_valid)
    else $error("result overwritten by read data");

endmodule

@@ rtl/multilevel_priority_ready_queue_top.sv @@
// Multilevel strict-priority ready queue: one FIFO of 6-bit process indices per level,
// level 0 most urgent. A dequeue that finds an entry passes through the S_READ state,
// spent on the registered read port of the shared entry storage; an enqueue and a
// dequeue with every level empty do not. The result register sits between the two
// channels, so the next item is taken in the cycle its predecessor's result transfers.
// Storage entries need no clearing after reset: only counted entries are ever read.
//
// Top level: joins mlprq_ctrl and mlprq_datapath; depends on mlprq_pkg.
module multilevel_priority_ready_queue_top
  import mlprq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_LEVELS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [2:0] priority_req,
  input  logic [5:0] proc_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [5:0] out_index,
  output logic [1:0] out_priority,
  output logic       all_empty
);

  cmd_t     cmd;
  dp_stat_t stat;

  mlprq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlprq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .priority_req (priority_req),
    .proc_index   (proc_index),
    .status       (status),
    .out_index    (out_index),
    .out_priority (out_priority),
    .all_empty    (all_empty)
  );

endmodule

@@ tb/tb_multilevel_priority_ready_queue_top.sv @@
// Self-checking testbench for the multilevel strict-priority ready queue.
// Mirrors the per-level FIFOs in its own model; depends on mlprq_pkg and
// multilevel_priority_ready_queue_top only.
module tb_multilevel_priority_ready_queue_top;
  import mlprq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH  = 64;
  localparam int NUM_LEVELS   = 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AFTER   = 300;   // transfers before the long receiver hold-off
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic       func;
    logic [2:0] prio;
    logic [5:0] idx;
    logic       wait_drained;  // offer only once every answer has come back
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] index;
    logic [1:0] level;
    logic       empty;
  } answer_t;

  typedef enum {PH_MIXED, PH_FILL, PH_DRAIN, PH_NOISE} phase_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = FN_ENQ;
  logic [2:0] priority_req = 3'd0;
  logic [5:0] proc_index = 6'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [5:0] out_index;
  logic [1:0] out_priority;
  logic       all_empty;

  multilevel_priority_ready_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_LEVELS (NUM_LEVELS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .priority_req(priority_req),
    .proc_index  (proc_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_index   (out_index),
    .out_priority(out_priority),
    .all_empty   (all_empty)
  );

  always #1 clk = ~clk;

  // Request plan, awaited answers and the mirrored level FIFOs
  request_t   request_plan[$];
  answer_t    awaited_answers[$];
  logic [5:0] mirror_store[NUM_LEVELS][QUEUE_DEPTH];
  int         mirror_head[NUM_LEVELS];
  int         mirror_count[NUM_LEVELS];

  request_t cur_req;
  int plan_total = 0;
  int sent_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int n_enq = 0, n_full = 0, n_badprio = 0, n_deq = 0, n_none = 0;

  initial begin
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      mirror_head[lv] = 0;
      mirror_count[lv] = 0;
    end
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("cycle %0d: %s", cycle_count, what);
  endtask

  // Work out the answer to one accepted request and advance the mirror
  task automatic predict_answer(input request_t rq);
    answer_t ans;
    bit      found;
    int      slot;
    ans = '0;
    ans.status = ST_OK;
    found = 0;
    if (rq.func == FN_ENQ) begin
      if (rq.prio >= NUM_LEVELS) begin
        ans.status = ST_BADPRIO;
        n_badprio++;
      end else if (mirror_count[rq.prio] >= QUEUE_DEPTH) begin
        ans.status = ST_FULL;
        n_full++;
      end else begin
        slot = (mirror_head[rq.prio] + mirror_count[rq.prio]) % QUEUE_DEPTH;
        mirror_store[rq.prio][slot] = rq.idx;
        mirror_count[rq.prio]++;
        n_enq++;
      end
    end else begin
      ans.status = ST_EMPTY;
      for (int lv = 0; lv < NUM_LEVELS && !found; lv++) begin
        if (mirror_count[lv] != 0) begin
          ans.index = mirror_store[lv][mirror_head[lv]];
          ans.level = 2'(lv);
          ans.status = ST_OK;
          mirror_head[lv] = (mirror_head[lv] + 1) % QUEUE_DEPTH;
          mirror_count[lv]--;
          found = 1;
        end
      end
      if (found) n_deq++;
      else n_none++;
    end
    ans.empty = 1'b1;
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      if (mirror_count[lv] != 0) ans.empty = 1'b0;
    awaited_answers.push_back(ans);
  endtask

  task automatic plan_request(input logic f, input logic [2:0] p, input logic [5:0] i,
                              input logic hold);
    request_t rq;
    rq.func = f;
    rq.prio = p;
    rq.idx = i;
    rq.wait_drained = hold;
    request_plan.push_back(rq);
  endtask

  function automatic logic [5:0] any_index();
    return 6'($urandom_range(0, 63));
  endfunction

  // Sender: offer planned requests with random gaps
  int tx_gap = 0;
  int tx_calm = 0;

  always @(posedge clk) begin : sender
    logic offer;
    int   r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        predict_answer(cur_req);
        sent_count++;
        offer = 1'b0;
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 60) tx_gap = 0;
          else if (r < 92) tx_gap = $urandom_range(1, 3);
          else tx_gap = $urandom_range(8, 30);
          if ($urandom_range(0, 99) < 2) tx_calm = $urandom_range(30, 60);
        end
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (request_plan.size() != 0 &&
                     !(request_plan[0].wait_drained && awaited_answers.size() != 0)) begin
          cur_req = request_plan.pop_front();
          func <= cur_req.func;
          priority_req <= cur_req.prio;
          proc_index <= cur_req.idx;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps offering
  int  rx_wait = 0;
  int  rx_calm = 0;
  bit  long_hold_done = 0;

  always @(posedge clk) begin : receiver
    int r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!long_hold_done && sent_count >= HOLD_AFTER) begin
        long_hold_done = 1;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) rx_calm = $urandom_range(30, 60);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_wait = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        end
      end
    end
  end

  // Monitor: compare each transferred answer with the oldest prediction
  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        note_failure($sformatf("unexpected answer status %0d index %0d level %0d empty %0d",
                               status, out_index, out_priority, all_empty));
      end else begin
        want = awaited_answers.pop_front();
        checked_count++;
        if (status !== want.status || out_index !== want.index ||
            out_priority !== want.level || all_empty !== want.empty)
          note_failure($sformatf(
            "expected status %0d index %0d level %0d empty %0d, got %0d %0d %0d %0d",
            want.status, want.index, want.level, want.empty,
            status, out_index, out_priority, all_empty));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_count, awaited_answers.size());
      $display("multilevel_priority_ready_queue_top verification failed");
      $finish;
    end
  end

  // Build the plan, release reset, wait for the last answer
  initial begin : plan_and_finish
    phase_kind_t kind;
    int          phase;
    int          len;
    int          lvl;
    int          r;
    int          random_added;
    logic        hold;

    // Directed: empty dequeue, every level, bad levels, priority order, FIFO order
    plan_request(FN_DEQ, 3'd0, 6'd63, 1'b0);
    plan_request(FN_ENQ, 3'd3, 6'd63, 1'b0);
    plan_request(FN_ENQ, 3'd0, 6'd0, 1'b0);
    plan_request(FN_ENQ, 3'd2, 6'd21, 1'b0);
    plan_request(FN_ENQ, 3'd1, 6'd42, 1'b0);
    for (int p = NUM_LEVELS; p < 8; p++) plan_request(FN_ENQ, 3'(p), 6'd63, 1'b0);
    for (int k = 0; k < 5; k++) plan_request(FN_DEQ, 3'd7, 6'd0, 1'b0);
    plan_request(FN_ENQ, 3'd2, 6'd7, 1'b0);
    plan_request(FN_ENQ, 3'd2, 6'd56, 1'b0);
    plan_request(FN_ENQ, 3'd0, 6'd33, 1'b0);
    for (int k = 0; k < 4; k++) plan_request(FN_DEQ, 3'd0, 6'd0, 1'b0);

    // Random phases; the first fills one level past full, the second mostly dequeues
    phase = 0;
    random_added = 0;
    while (random_added < RANDOM_ITEMS) begin
      if (phase == 0) kind = PH_FILL;
      else if (phase == 1) kind = PH_DRAIN;
      else begin
        r = $urandom_range(0, 99);
        if (r < 40) kind = PH_MIXED;
        else if (r < 62) kind = PH_FILL;
        else if (r < 88) kind = PH_DRAIN;
        else kind = PH_NOISE;
      end
      lvl = (phase == 0) ? NUM_LEVELS - 1 : $urandom_range(0, NUM_LEVELS - 1);
      case (kind)
        PH_FILL:  len = $urandom_range(66, 80);
        PH_DRAIN: len = $urandom_range(30, 100);
        PH_NOISE: len = $urandom_range(10, 30);
        default:  len = $urandom_range(20, 60);
      endcase
      for (int k = 0; k < len; k++) begin
        // pause the sender once mid-run until the block has answered everything
        hold = (phase == 12 && k == 0);
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL: begin
            // the opening fill only enqueues, so it always runs into a full level
            if (r < 90 || phase == 0) plan_request(FN_ENQ, 3'(lvl), any_index(), hold);
            else plan_request(FN_DEQ, 3'($urandom_range(0, 7)), any_index(), hold);
          end
          PH_DRAIN: begin
            if (r < 85) plan_request(FN_DEQ, 3'($urandom_range(0, 7)), any_index(), hold);
            else plan_request(FN_ENQ, 3'($urandom_range(0, NUM_LEVELS - 1)), any_index(),
                              hold);
          end
          PH_NOISE: begin
            plan_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), any_index(),
                         hold);
          end
          default: begin
            if (r < 50) plan_request(FN_ENQ, 3'($urandom_range(0, NUM_LEVELS - 1)),
                                     any_index(), hold);
            else if (r < 56) plan_request(FN_ENQ, 3'($urandom_range(NUM_LEVELS, 7)),
                                          any_index(), hold);
            else plan_request(FN_DEQ, 3'($urandom_range(0, 7)), any_index(), hold);
          end
        endcase
      end
      random_added += len;
      phase++;
    end
    plan_total = request_plan.size();

    // Hold reset, then release it and let the driver run
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < plan_total || awaited_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests in %0d cycles: %0d enqueued, %0d on a full level,",
             sent_count, cycle_count, n_enq, n_full);
    $display("%0d on a bad level, %0d dequeued, %0d with nothing ready; %0d answers checked",
             n_badprio, n_deq, n_none, checked_count);
    if (fail_count == 0) begin
      $display("multilevel_priority_ready_queue_top verification clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("multilevel_priority_ready_queue_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mlprq_pkg.sv
rtl/mlprq_datapath.sv
rtl/mlprq_ctrl.sv
rtl/multilevel_priority_ready_queue_top.sv
tb/tb_multilevel_priority_ready_queue_top.sv
